// File: sv/sorted_sleep_timer_queue_core_defines.svh
// Assertion macros used by the checker file of the sleep timer queue.
`ifndef SORTED_SLEEP_TIMER_QUEUE_CORE_DEFINES_SVH
`define SORTED_SLEEP_TIMER_QUEUE_CORE_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define SSTQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Checked on every rising edge, reset included.
`define SSTQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// File: sv/sstq_pkg.sv
// Package with the types, codes and constants of the sleep timer queue.
package sstq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int MAX_RESULTS         = 16;
   localparam int MS_PER_SECOND       = 1000;

   localparam int TIME_W  = 32;
   localparam int SECS_W  = 16;
   localparam int PID_W   = 8;
   localparam int KIND_W  = 2;
   localparam int PROD_W  = 26;
   localparam int ENTRY_W = TIME_W + PID_W;

   typedef enum logic {
      OP_SLEEP = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_REJECTED = 2'd1,
      KIND_WOKEN    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [TIME_W-1:0] wake;
      logic [PID_W-1:0]  owner;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_WALK,
      ST_SHIFT,
      ST_ACK,
      ST_RD,
      ST_CHK,
      ST_EMIT,
      ST_FIN
   } state_type;

endpackage

// File: sv/sstq_ifs.sv
// Valid/ready channel interfaces for the request and response sides.
interface sstq_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [sstq_pkg::TIME_W-1:0] current_time;
   logic [sstq_pkg::SECS_W-1:0] sleep_seconds;
   logic [sstq_pkg::PID_W-1:0]  process_id;

   modport source (output valid, output operation, output current_time,
                   output sleep_seconds, output process_id, input ready);
   modport sink   (input valid, input operation, input current_time,
                   input sleep_seconds, input process_id, output ready);
endinterface

interface sstq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sstq_pkg::KIND_W-1:0] kind;
   logic [sstq_pkg::PID_W-1:0]  woken_id;
   logic [sstq_pkg::TIME_W-1:0] wake_time;
   logic                        last;

   modport source (output valid, output kind, output woken_id, output wake_time,
                   output last, input ready);
   modport sink   (input valid, input kind, input woken_id, input wake_time,
                   input last, output ready);
endinterface

// File: sv/sstq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sstq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sorted_sleep_timer_queue_core.sv
// Sorted sleep timer queue: sleepers kept in wakeup order, woken by clock ticks.
//
// The block holds up to QUEUE_DEPTH sleepers in a circular buffer in RAM, kept
// sorted by wakeup time, with a head pointer and an entry count in flip-flops.
// A sleep request (operation 0) computes its wakeup time as current_time plus
// sleep_seconds times 1000, saturating at the top of the 32-bit range, and is
// inserted after every entry with an earlier or equal wakeup time, so equal
// times keep arrival order. It always gives exactly one response item: kind 0
// when stored, kind 1 when the queue is full, each carrying the wakeup time and
// last set. A clock tick (operation 1) wakes every head entry whose wakeup time
// is at or before current_time, at most 16 per tick, one response item of kind
// 2 per entry, with last on the final one; a tick that wakes nothing gives no
// response. One item is worked on at a time and req ready is low meanwhile.
// All walking goes through one RAM read port and one shared magnitude
// comparator. Req ready is high again once the last response item of a
// request is loaded, or once a tick finds nothing due. A sleep walks back from
// its free slot, moving each entry with a later wakeup time down one slot,
// until an entry with an earlier or equal wakeup time or the head of the queue
// ends the walk. A tick reads the entries from the head and holds each due one
// back until the next read shows whether it is the last. A response item waits
// in an output register, and a stalled consumer holds the work until that
// register can take the next item.
// No clearing pass is needed after reset: only slots below the entry count are
// ever read.
module sorted_sleep_timer_queue_core #(
   parameter int QUEUE_DEPTH = sstq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input logic         clock,
   input logic         reset,
   sstq_req_if.sink    req_if,
   sstq_rsp_if.source  rsp_if
);

   import sstq_pkg::*;

   // Address, count and wrap-sum widths follow from the queue depth.
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;
   // At most this many entries are woken by one tick.
   localparam int RESULT_CAP = (QUEUE_DEPTH < MAX_RESULTS) ? QUEUE_DEPTH : MAX_RESULTS;

   // Slot of the entry that sits a given distance behind the head.
   function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(QUEUE_DEPTH)) begin
         sum = sum - SW'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // Control state.
   state_type     state_ff,      state_in;
   logic [AW-1:0] head_ff,       head_in;
   logic [CW-1:0] count_ff,      count_in;
   logic [CW-1:0] idx_ff,        idx_in;
   logic          pend_valid_ff, pend_valid_in;
   logic          rsp_valid_ff,  rsp_valid_in;

   // Working payload of the item in flight.
   logic [TIME_W-1:0] key_ff,  key_in;
   logic [SECS_W-1:0] secs_ff, secs_in;
   logic [PID_W-1:0]  pid_ff,  pid_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   kind_type          ack_kind_ff, ack_kind_in;
   entry_type         pend_ff, pend_in;

   // Response output register.
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [PID_W-1:0]  rsp_id_ff,   rsp_id_in;
   logic [TIME_W-1:0] rsp_wake_ff, rsp_wake_in;
   logic              rsp_last_ff, rsp_last_in;

   // RAM port signals.
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_entry;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [ENTRY_W-1:0] rd_bits;
   entry_type         rd_entry;

   logic              out_free;
   logic              cmp_gt;
   logic [TIME_W:0]   wake_sum;

   sstq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_entry = entry_type'(rd_bits);

   // The one shared comparator: is the entry just read due later than the key?
   // The key holds the new wakeup time during a sleep and the tick time during
   // a tick.
   assign cmp_gt = rd_entry.wake > key_ff;

   // The output register can take a new item when it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign wake_sum = {1'b0, key_ff} + (TIME_W + 1)'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      secs_ff     <= secs_in;
      pid_ff      <= pid_in;
      prod_ff     <= prod_in;
      ack_kind_ff <= ack_kind_in;
      pend_ff     <= pend_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_wake_ff <= rsp_wake_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      key_in        = key_ff;
      secs_in       = secs_ff;
      pid_in        = pid_ff;
      prod_in       = prod_ff;
      ack_kind_in   = ack_kind_ff;
      pend_in       = pend_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_wake_in   = rsp_wake_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;

      wr_en          = 1'b0;
      wr_addr        = wrap_addr(head_ff, idx_ff);
      wr_entry.wake  = key_ff;
      wr_entry.owner = pid_ff;
      rd_en          = 1'b0;
      rd_addr        = wrap_addr(head_ff, idx_ff);
      req_if.ready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               key_in        = req_if.current_time;
               secs_in       = req_if.sleep_seconds;
               pid_in        = req_if.process_id;
               idx_in        = '0;
               pend_valid_in = 1'b0;
               state_in      = (op_type'(req_if.operation) == OP_TICK) ? ST_RD : ST_MUL;
            end
         end

         ST_MUL: begin
            prod_in  = PROD_W'(secs_ff) * PROD_W'(MS_PER_SECOND);
            state_in = ST_ADD;
         end

         ST_ADD: begin
            // Saturate the wakeup time at the top of the time range.
            key_in = wake_sum[TIME_W] ? '1 : wake_sum[TIME_W-1:0];
            if (count_ff == CW'(QUEUE_DEPTH)) begin
               ack_kind_in = KIND_REJECTED;
               state_in    = ST_ACK;
            end else begin
               ack_kind_in = KIND_ACCEPTED;
               idx_in      = count_ff;
               state_in    = ST_WALK;
            end
         end

         ST_WALK: begin
            // idx is the free slot; look at the entry just in front of it.
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = ST_ACK;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = wrap_addr(head_ff, idx_ff - 1'b1);
               state_in = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            wr_en = 1'b1;
            if (cmp_gt) begin
               // A later entry moves back one slot to make room.
               wr_entry = rd_entry;
               idx_in   = idx_ff - 1'b1;
               state_in = ST_WALK;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = ST_ACK;
            end
         end

         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = ack_kind_ff;
               rsp_id_in    = pid_ff;
               rsp_wake_in  = key_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_RD: begin
            if (idx_ff < count_ff && idx_ff < CW'(RESULT_CAP)) begin
               rd_en    = 1'b1;
               state_in = ST_CHK;
            end else begin
               state_in = ST_FIN;
            end
         end

         ST_CHK: begin
            // A due entry is held back one step so that the last one is known.
            if (cmp_gt) begin
               state_in = ST_FIN;
            end else if (pend_valid_ff) begin
               state_in = ST_EMIT;
            end else begin
               pend_in       = rd_entry;
               pend_valid_in = 1'b1;
               idx_in        = idx_ff + 1'b1;
               state_in      = ST_RD;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_WOKEN;
               rsp_id_in    = pend_ff.owner;
               rsp_wake_in  = pend_ff.wake;
               rsp_last_in  = 1'b0;
               pend_in      = rd_entry;
               idx_in       = idx_ff + 1'b1;
               state_in     = ST_RD;
            end
         end

         ST_FIN: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_WOKEN;
               rsp_id_in     = pend_ff.owner;
               rsp_wake_in   = pend_ff.wake;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               head_in       = wrap_addr(head_ff, idx_ff);
               count_in      = count_ff - idx_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.kind      = rsp_kind_ff;
   assign rsp_if.woken_id  = rsp_id_ff;
   assign rsp_if.wake_time = rsp_wake_ff;
   assign rsp_if.last      = rsp_last_ff;

endmodule

// File: sv/sstq_checker.sv
// Port-level checker for the sleep timer queue and its bind to the top level.
`include "sorted_sleep_timer_queue_core_defines.svh"

module sstq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sstq_pkg::KIND_W-1:0] rsp_kind,
   input logic [sstq_pkg::PID_W-1:0]  rsp_woken_id,
   input logic [sstq_pkg::TIME_W-1:0] rsp_wake_time,
   input logic                        rsp_last
);

   import sstq_pkg::*;

   `SSTQ_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_woken_id) && $stable(rsp_wake_time) && $stable(rsp_last), "response item changed while stalled")

   `SSTQ_ASSERT(a_kind_legal, clock, reset, rsp_valid |-> rsp_kind == KIND_ACCEPTED || rsp_kind == KIND_REJECTED || rsp_kind == KIND_WOKEN, "response kind out of range")

   `SSTQ_ASSERT(a_sleep_last, clock, reset, rsp_valid && rsp_kind != KIND_WOKEN |-> rsp_last, "sleep response without last")

   `SSTQ_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while busy")

   `SSTQ_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "response valid right after reset")

endmodule

bind sorted_sleep_timer_queue_core sstq_checker u_sstq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_kind      (rsp_if.kind),
   .rsp_woken_id  (rsp_if.woken_id),
   .rsp_wake_time (rsp_if.wake_time),
   .rsp_last      (rsp_if.last)
);
